### hdl/docu_pkg.sv
// ----------------------------------------------------------------------------
// Damped orbit camera package
// Shared widths, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package docu_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int ROT_STEPS = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

    localparam int IN_W  = 72;
    localparam int OUT_W = 48;

    localparam logic [15:0] CORDIC_GAIN = 16'd39797;
    localparam logic signed [28:0] HALF_PI_24 = 29'sd26353589;
    localparam logic signed [28:0] PI_24      = 29'sd52707179;
    localparam logic signed [16:0] PI_13      = 17'sd25736;
    localparam logic signed [16:0] TWO_PI_13  = 17'sd51472;

    localparam logic signed [24:0] ZOOM_MIN = 25'sd7168;
    localparam logic signed [24:0] ZOOM_MAX = 25'sd20480;
    localparam logic signed [16:0] VERT_MAX = 17'sd8192;
    localparam logic [15:0] DIV_MIN = 16'd4096;
    localparam logic signed [24:0] ZSPEED_MAX = 25'sd8388607;
    localparam logic signed [24:0] ZSPEED_MIN = -25'sd8388608;
    localparam logic signed [17:0] EYE_MAX = 18'sd20480;

    localparam logic signed [15:0] H_ANG_RST = 16'sd12868;
    localparam logic [13:0] V_ANG_RST = 14'd3574;
    localparam logic [14:0] ZOOM_RST  = 15'd10240;
    localparam logic [15:0] DAMP_RST  = 16'd5120;

    localparam logic [1:0] REG_X_DAMP = 2'd0;
    localparam logic [1:0] REG_Y_DAMP = 2'd1;
    localparam logic [1:0] REG_Z_DAMP = 2'd2;

    function automatic logic [23:0] atan_entry(input logic [4:0] idx);
        logic [23:0] v;
        unique case (idx)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

### hdl/docu_div.sv
// ----------------------------------------------------------------------------
// Damping divider
// Restoring divider, one quotient bit per cycle: speed * 4096 / divisor,
// truncated toward zero.
// ----------------------------------------------------------------------------
module docu_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [23:0] i_speed,
    input  logic        [15:0] i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [23:0] o_quot
);
    import docu_pkg::*;

    logic [35:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_busy;
    logic        r_done;
    logic [23:0] mag;
    logic [16:0] rem_sh;
    logic        fits;

    assign mag    = i_speed[23] ? 24'(-i_speed) : 24'(i_speed);
    assign rem_sh = {r_rem[15:0], r_num[35]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_num  <= {mag, 12'd0};
                r_neg  <= i_speed[23];
                r_div  <= (i_divisor < DIV_MIN) ? DIV_MIN : i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
                r_num <= {r_num[34:0], fits};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd35) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_num[23:0]) : $signed(r_num[23:0]);

endmodule

### hdl/docu_cordic.sv
// ----------------------------------------------------------------------------
// Rotation unit
// Iterative CORDIC: zoom times cosine and sine of a Q3.13 angle, Q5.10 out.
// ----------------------------------------------------------------------------
module docu_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic        [14:0] i_zoom,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output logic signed [17:0] o_cos,
    output logic signed [17:0] o_sin
);
    import docu_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_ITER, C_DONE} t_cstate;

    t_cstate r_state;
    logic signed [32:0] r_x, r_y;
    logic signed [28:0] r_z;
    logic [4:0]  r_i;
    logic        r_neg;
    logic        r_done;
    logic signed [17:0] r_cos, r_sin;
    logic signed [28:0] z0;
    logic signed [32:0] xs, ys, xf, yf, xr, yr;
    logic signed [28:0] at;

    assign z0 = 29'(i_angle) <<< 11;
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = $signed({5'd0, atan_entry(r_i)});
    assign xf = r_neg ? -r_x : r_x;
    assign yf = r_neg ? -r_y : r_y;
    assign xr = (xf + 33'sd32768) >>> 16;
    assign yr = (yf + 33'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x <= $signed({2'd0, 31'(i_zoom * CORDIC_GAIN)});
                        r_y <= '0;
                        r_i <= 5'd0;
                        if (z0 > HALF_PI_24) begin
                            r_z <= z0 - PI_24; r_neg <= 1'b1;
                        end else if (z0 < -HALF_PI_24) begin
                            r_z <= z0 + PI_24; r_neg <= 1'b1;
                        end else begin
                            r_z <= z0; r_neg <= 1'b0;
                        end
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (!r_z[28]) begin
                        r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + at;
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(ROT_STEPS - 1)) r_state <= C_DONE;
                end
                C_DONE: begin
                    r_cos   <= xr[17:0];
                    r_sin   <= yr[17:0];
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

### hdl/damped_orbit_camera_update_unit.sv
// ----------------------------------------------------------------------------
// Damped orbit camera update unit
// One beat in per frame: updates speeds, angles and zoom, returns eye position.
//
// Channel   Dir  Handshake                      Contents
// s_axis    in   s_axis_tvalid/s_axis_tready    frame controls
// m_axis    out  m_axis_tvalid/m_axis_tready    eye position
// cfg       in   i_cfg_valid/o_cfg_ready        damping divisors
//
// A frame runs through accept, two setup states, three divisions (36 quotient steps
// each, plus start and handoff) on one shared divider, two CORDIC rotations on one
// shared rotation unit, and one output load.
// Reset restores angles, zoom, speeds and divisors. A finished result waits in
// the output register; the next frame is accepted meanwhile and holds at the
// end until that register is free.
// ----------------------------------------------------------------------------
module damped_orbit_camera_update_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // restart, x_kick_valid, x_kick, y_kick_valid, y_kick, zoom_kick,
    // zoom_set_valid, zoom_set, pad
    input  logic [docu_pkg::IN_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // eye_x, eye_y, eye_z, pad
    output logic [docu_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import docu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP1, S_PREP2, S_DIV_GO, S_DIV_WAIT, S_ROT_GO, S_ROT_WAIT, S_FIN
    } t_state;

    t_state r_state;
    logic [15:0] r_xdiv, r_ydiv, r_zdiv;
    logic [IN_W-1:0] r_in;
    logic signed [15:0] r_h_ang, r_h_spd, r_v_spd;
    logic [13:0] r_v_ang;
    logic [14:0] r_zoom;
    logic [15:0] r_zoom_tmp;
    logic signed [23:0] r_z_spd;
    logic [1:0]  r_sel;
    logic signed [15:0] r_ex, r_ez;
    logic [14:0] r_ey;
    logic        r_out_valid;
    logic [OUT_W-1:0] r_out;

    logic signed [15:0] base_h_spd, base_v_spd;
    logic signed [23:0] base_z_spd;
    logic [14:0] base_zoom;
    logic signed [24:0] zs_sum, zoom_sum;
    logic signed [16:0] h_sum, v_sum;
    logic signed [23:0] div_in;
    logic [15:0] div_d;
    logic        div_busy, div_done;
    logic signed [23:0] div_q;
    logic [14:0] rot_zoom;
    logic signed [15:0] rot_ang;
    logic        rot_done;
    logic signed [17:0] rot_cos, rot_sin;
    logic        div_start, rot_start;

    assign base_h_spd = r_in[0] ? 16'sd0 : r_h_spd;
    assign base_v_spd = r_in[0] ? 16'sd0 : r_v_spd;
    assign base_z_spd = r_in[0] ? 24'sd0 : r_z_spd;
    assign base_zoom  = r_in[0] ? ZOOM_RST : r_zoom;
    assign zs_sum = 25'(base_z_spd) + 25'($signed(r_in[50:35]));
    assign h_sum  = 17'(r_h_ang) + 17'(r_h_spd);
    assign v_sum  = $signed({3'd0, r_v_ang}) + 17'(r_v_spd);
    assign zoom_sum = $signed({9'd0, r_zoom_tmp}) + 25'(r_z_spd);

    always_comb begin
        unique case (r_sel)
            2'd0:    begin div_in = 24'(r_h_spd); div_d = r_xdiv; end
            2'd1:    begin div_in = 24'(r_v_spd); div_d = r_ydiv; end
            default: begin div_in = r_z_spd;      div_d = r_zdiv; end
        endcase
    end

    assign div_start = (r_state == S_DIV_GO);
    assign rot_start = (r_state == S_ROT_GO);
    assign rot_zoom  = r_zoom;
    assign rot_ang   = r_sel[0] ? $signed({2'd0, r_v_ang}) : r_h_ang;

    docu_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_speed   (div_in),
        .i_divisor (div_d),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    docu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_zoom  (rot_zoom),
        .i_angle (rot_ang),
        .o_done  (rot_done),
        .o_cos   (rot_cos),
        .o_sin   (rot_sin)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xdiv <= DAMP_RST;
            r_ydiv <= DAMP_RST;
            r_zdiv <= DAMP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_X_DAMP: r_xdiv <= i_cfg_data;
                REG_Y_DAMP: r_ydiv <= i_cfg_data;
                REG_Z_DAMP: r_zdiv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sel       <= 2'd0;
            r_h_ang     <= H_ANG_RST;
            r_v_ang     <= V_ANG_RST;
            r_zoom      <= ZOOM_RST;
            r_h_spd     <= '0;
            r_v_spd     <= '0;
            r_z_spd     <= '0;
        end else begin
            if (m_axis_tready && r_state != S_FIN) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in    <= s_axis_tdata;
                        r_state <= S_PREP1;
                    end
                end
                S_PREP1: begin
                    if (r_in[0]) begin
                        r_h_ang <= H_ANG_RST;
                        r_v_ang <= V_ANG_RST;
                    end
                    r_h_spd <= r_in[1]  ? $signed(r_in[17:2])  : base_h_spd;
                    r_v_spd <= r_in[18] ? $signed(r_in[34:19]) : base_v_spd;
                    if (zs_sum > ZSPEED_MAX)      r_z_spd <= ZSPEED_MAX[23:0];
                    else if (zs_sum < ZSPEED_MIN) r_z_spd <= ZSPEED_MIN[23:0];
                    else                          r_z_spd <= zs_sum[23:0];
                    r_zoom_tmp <= r_in[51] ? r_in[67:52] : {1'b0, base_zoom};
                    r_state <= S_PREP2;
                end
                S_PREP2: begin
                    if (h_sum >= PI_13)       r_h_ang <= 16'(h_sum - TWO_PI_13);
                    else if (h_sum < -PI_13)  r_h_ang <= 16'(h_sum + TWO_PI_13);
                    else                      r_h_ang <= h_sum[15:0];
                    if (v_sum < 0)             r_v_ang <= '0;
                    else if (v_sum > VERT_MAX) r_v_ang <= VERT_MAX[13:0];
                    else                       r_v_ang <= v_sum[13:0];
                    if (zoom_sum < ZOOM_MIN)      r_zoom <= ZOOM_MIN[14:0];
                    else if (zoom_sum > ZOOM_MAX) r_zoom <= ZOOM_MAX[14:0];
                    else                          r_zoom <= zoom_sum[14:0];
                    r_sel   <= 2'd0;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        unique case (r_sel)
                            2'd0:    r_h_spd <= div_q[15:0];
                            2'd1:    r_v_spd <= div_q[15:0];
                            default: r_z_spd <= div_q;
                        endcase
                        if (r_sel == 2'd2) begin
                            r_sel   <= 2'd0;
                            r_state <= S_ROT_GO;
                        end else begin
                            r_sel   <= r_sel + 2'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_ROT_GO: r_state <= S_ROT_WAIT;
                S_ROT_WAIT: begin
                    if (rot_done) begin
                        if (r_sel[0]) begin
                            if (rot_sin < 0)            r_ey <= '0;
                            else if (rot_sin > EYE_MAX) r_ey <= EYE_MAX[14:0];
                            else                        r_ey <= rot_sin[14:0];
                            r_state <= S_FIN;
                        end else begin
                            if (rot_cos > EYE_MAX)       r_ex <= EYE_MAX[15:0];
                            else if (rot_cos < -EYE_MAX) r_ex <= 16'(-EYE_MAX);
                            else                         r_ex <= rot_cos[15:0];
                            if (rot_sin > EYE_MAX)       r_ez <= EYE_MAX[15:0];
                            else if (rot_sin < -EYE_MAX) r_ez <= 16'(-EYE_MAX);
                            else                         r_ez <= rot_sin[15:0];
                            r_sel   <= 2'd1;
                            r_state <= S_ROT_GO;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= {1'b0, r_ez, r_ey, r_ex};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second beat taken during a frame");
    a_eye_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:16] <= 15'd20480))
        else $error("eye height out of range");
`endif

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Damped orbit camera update unit testbench
// Drives frame beats with random gaps and checks every eye position beat
// against a cycle-free predictor of the camera state, across several
// damping divisor settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import docu_pkg::*;

    typedef struct packed {
        logic [15:0] zs;
        logic        zs_v;
        logic [15:0] zk;
        logic [15:0] yk;
        logic        yk_v;
        logic [15:0] xk;
        logic        xk_v;
        logic        restart;
    } t_frame;

    typedef struct {
        logic [15:0] ex;
        logic [14:0] ey;
        logic [15:0] ez;
    } t_eye;

    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    damped_orbit_camera_update_unit uut (.*);

    initial forever #2 i_clk = ~i_clk;

    t_frame frame_q[$];
    t_eye   eye_q[$];
    int     errors = 0;
    bit     run_cfg = 0;
    int     send_gap = 0, recv_gap = 0;

    longint dmp [3];
    longint h_ang, v_ang, zoom_d, h_spd, v_spd, z_spd;

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
        return $urandom_range(0, 4);
    endfunction

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint damped(longint spd, longint div);
        longint d = div < 4096 ? 4096 : div;
        return (spd * 4096) / d;
    endfunction

    task automatic cordic(input longint zm, input longint ang,
                          output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit neg;
        z = ang * 2048;
        x = zm * 39797;
        y = 0;
        neg = 0;
        if (z > 26353589) begin
            z -= 52707179; neg = 1;
        end else if (z < -26353589) begin
            z += 52707179; neg = 1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_entry(5'(i)));
            end else begin
                x += ys; y -= xs; z += longint'(atan_entry(5'(i)));
            end
        end
        if (neg) begin
            x = -x; y = -y;
        end
        c = shr(x + 32768, 16);
        s = shr(y + 32768, 16);
    endtask

    task automatic restore_camera();
        h_ang = 12868; v_ang = 3574; zoom_d = 10240;
        h_spd = 0; v_spd = 0; z_spd = 0;
    endtask

    task automatic predict_eye(input t_frame f);
        longint zm, h, v, ex, ey, ez, dummy;
        t_eye e;
        if (f.restart) restore_camera();
        if (f.xk_v) h_spd = longint'($signed(f.xk));
        if (f.yk_v) v_spd = longint'($signed(f.yk));
        z_spd = clip(z_spd + longint'($signed(f.zk)), -8388608, 8388607);
        zm = f.zs_v ? longint'(f.zs) : zoom_d;
        h = h_ang + h_spd;
        if (h >= 25736) h -= 51472;
        else if (h < -25736) h += 51472;
        h_ang = h;
        h_spd = damped(h_spd, dmp[0]);
        v = v_ang + v_spd;
        v_ang = clip(v, 0, 8192);
        v_spd = damped(v_spd, dmp[1]);
        zoom_d = clip(zm + z_spd, 7168, 20480);
        z_spd = damped(z_spd, dmp[2]);
        cordic(zoom_d, h_ang, ex, ez);
        cordic(zoom_d, v_ang, dummy, ey);
        e.ex = 16'(clip(ex, -20480, 20480));
        e.ez = 16'(clip(ez, -20480, 20480));
        e.ey = 15'(clip(ey, 0, 20480));
        eye_q.push_back(e);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && !run_cfg) begin
            if (s_axis_tvalid && s_axis_tready) begin
                s_axis_tvalid <= 0;
                send_gap <= pick_gap();
            end else if (!s_axis_tvalid) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                else if (frame_q.size() > 0) begin
                    s_axis_tdata <= IN_W'(t_frame'(frame_q[0]));
                    predict_eye(frame_q.pop_front());
                    s_axis_tvalid <= 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_eye e;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (eye_q.size() == 0) begin
                    $error("eye beat with no frame pending");
                    errors++;
                end else begin
                    e = eye_q.pop_front();
                    if (m_axis_tdata[15:0] !== e.ex) begin
                        $error("eye_x exp %0d got %0d", $signed(e.ex),
                               $signed(m_axis_tdata[15:0]));
                        errors++;
                    end
                    if (m_axis_tdata[30:16] !== e.ey) begin
                        $error("eye_y exp %0d got %0d", e.ey, m_axis_tdata[30:16]);
                        errors++;
                    end
                    if (m_axis_tdata[46:31] !== e.ez) begin
                        $error("eye_z exp %0d got %0d", $signed(e.ez),
                               $signed(m_axis_tdata[46:31]));
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 0;
            end else if (m_axis_tready && m_axis_tvalid) begin
                recv_gap <= pick_gap();
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        dmp[idx] = val;
    endtask

    task automatic drain();
        while (frame_q.size() > 0 || s_axis_tvalid || eye_q.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_frame rand_frame();
        t_frame f;
        f.restart = ($urandom_range(0, 39) == 0);
        f.xk_v = ($urandom_range(0, 3) == 0);
        f.xk = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 1200)) - 600);
        f.yk_v = ($urandom_range(0, 3) == 0);
        f.yk = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 800)) - 400);
        f.zk = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($signed($urandom_range(0, 600)) - 300);
        f.zs_v = ($urandom_range(0, 9) == 0);
        f.zs = 16'($urandom);
        return f;
    endfunction

    function automatic t_frame mk(bit r, bit xv, int x, bit yv, int y, int z, bit sv, int s);
        t_frame f;
        f.restart = r; f.xk_v = xv; f.xk = 16'(x); f.yk_v = yv; f.yk = 16'(y);
        f.zk = 16'(z); f.zs_v = sv; f.zs = 16'(s);
        return f;
    endfunction

    initial begin
        logic [15:0] divs[3];
        dmp[0] = 5120; dmp[1] = 5120; dmp[2] = 5120;
        restore_camera();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        frame_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
        frame_q.push_back(mk(0, 1, 32767, 1, 32767, 32767, 0, 0));
        frame_q.push_back(mk(0, 1, -32768, 1, -32768, -32768, 0, 0));
        frame_q.push_back(mk(0, 0, 0, 0, 0, 32767, 1, 65535));
        for (int i = 0; i < 6; i++) frame_q.push_back(mk(0, 0, 0, 0, 0, 32767, 0, 0));
        frame_q.push_back(mk(1, 0, 0, 0, 0, 0, 1, 0));
        frame_q.push_back(mk(0, 1, 12868, 1, 5000, 0, 0, 0));
        frame_q.push_back(mk(0, 1, -25000, 1, -9000, -32768, 0, 0));
        frame_q.push_back(mk(1, 1, -1, 1, 1, 1, 1, 7168));
        frame_q.push_back(mk(0, 0, 0, 0, 0, 0, 1, 20480));
        frame_q.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0));
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            run_cfg = 1;
            for (int r = 0; r < 3; r++) begin
                case (ph)
                    0: divs[r] = 16'd4096;
                    1: divs[r] = 16'd65535;
                    2: divs[r] = 16'd0;
                    3: divs[r] = 16'($urandom_range(0, 4095));
                    default: divs[r] = 16'($urandom_range(4096, 8192));
                endcase
                write_reg(r[1:0] == 0 ? REG_X_DAMP : (r == 1 ? REG_Y_DAMP : REG_Z_DAMP),
                          divs[r]);
            end
            run_cfg = 0;
            for (int i = 0; i < 230; i++) frame_q.push_back(rand_frame());
            drain();
        end
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

### files.f
hdl/docu_pkg.sv
hdl/docu_div.sv
hdl/docu_cordic.sv
hdl/damped_orbit_camera_update_unit.sv
dv/testbench.sv
